// File: rtl/core/e2r_pkg.sv
`timescale 1ns / 1ps
// Package for the Euler angle to rotation matrix block: payload words, matrix
// type, fixed-point constants, CORDIC arctangent table and shared helpers.
// Depends on nothing; used by every module under rtl/core.
package e2r_pkg;

	// Rotation order codes carried in the operation field
	localparam logic OP_XYZ = 1'b0;
	localparam logic OP_ZYX = 1'b1;

	typedef enum logic [1:0] {
		AXIS_X,
		AXIS_Y,
		AXIS_Z
	} axis_t;

	typedef struct packed {
		logic               operation;
		logic signed [31:0] first_angle;
		logic signed [31:0] second_angle;
		logic signed [31:0] third_angle;
	} e2r_in_t;

	typedef struct packed {
		logic signed [31:0] row0_col0;
		logic signed [31:0] row0_col1;
		logic signed [31:0] row0_col2;
		logic signed [31:0] row1_col0;
		logic signed [31:0] row1_col1;
		logic signed [31:0] row1_col2;
		logic signed [31:0] row2_col0;
		logic signed [31:0] row2_col1;
		logic signed [31:0] row2_col2;
	} e2r_out_t;

	typedef logic signed [31:0] ent_t;
	typedef ent_t mat_t [9];

	// Latencies of the sub-blocks, in clock cycles
	localparam int PHASE_LAT  = 4;
	localparam int CORDIC_STEPS = 31;
	localparam int CORDIC_LAT = CORDIC_STEPS + 2;
	localparam int MM_LAT     = 2;
	localparam int ROT_LAT    = PHASE_LAT + CORDIC_LAT;
	localparam int TOTAL_LAT  = ROT_LAT + 2 * MM_LAT;

	// Fixed-point constants
	localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;
	localparam logic [64:0] DEG_RECIP  = 65'd6108397933;   // ceil(2^38 / 45)
	localparam logic [30:0] FRAC_RECIP = 31'd46604;        // ceil(2^21 / 45)
	localparam logic [63:0] RAD_TO_PHASE = 64'd2734261102;
	localparam logic signed [64:0] PI_Q30 = 65'sd3373259426;
	localparam int XW = 34;                                // CORDIC x/y width
	localparam logic signed [XW-1:0] CORDIC_GAIN = 34'sd652032874;

	localparam logic [31:0] ATAN_TABLE [CORDIC_STEPS] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
		32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
		32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
		32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
		32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
		32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
		32'h00000001
	};

	// Clamp to +-1.0 in Q2.30
	function automatic ent_t sat_q30(input logic signed [63:0] v);
		ent_t r;
		if (v > 64'sd1073741824) begin
			r = ONE_Q30;
		end else if (v < -64'sd1073741824) begin
			r = -ONE_Q30;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// Elementary rotation about one axis from its cosine and sine
	function automatic mat_t make_rot(input axis_t axis, input ent_t c, input ent_t s);
		mat_t m;
		for (int k = 0; k < 9; k++) begin
			m[k] = '0;
		end
		unique case (axis)
			AXIS_X: begin
				m[0] = ONE_Q30; m[4] = c; m[5] = -s; m[7] = s; m[8] = c;
			end
			AXIS_Y: begin
				m[0] = c; m[2] = s; m[4] = ONE_Q30; m[6] = -s; m[8] = c;
			end
			default: begin
				m[0] = c; m[1] = -s; m[3] = s; m[4] = c; m[8] = ONE_Q30;
			end
		endcase
		return m;
	endfunction

endpackage

// File: rtl/core/e2r_phase.sv
`timescale 1ns / 1ps
// Angle to CORDIC residual: unit conversion to a 34-bit turn phase, quadrant
// split and scaling to Q30 radians, four register stages. Uses e2r_pkg.
module e2r_phase (
	input  logic               clk,
	input  logic signed [31:0] angle,
	input  logic               deg,
	output logic [1:0]         quad,
	output logic signed [31:0] z
);

	localparam logic [64:0] DEG_RECIP_W = e2r_pkg::DEG_RECIP;

	logic [31:0] mag;
	logic [64:0] dprod;
	logic [63:0] rprod;

	logic [31:0] m_s1;
	logic [26:0] qd_s1;
	logic [33:0] pr_s1;
	logic        neg_s1, deg_s1;

	logic [31:0] qm;
	logic [5:0]  rem_s2;
	logic [25:0] qd_s2;
	logic [33:0] pr_s2;
	logic        neg_s2, deg_s2;

	logic [14:0] v2;
	logic [30:0] q2prod;
	logic [33:0] pdeg, phase, sph, t;
	logic [1:0]  quad_s3;
	logic signed [31:0] r_s3;

	logic [1:0]  quad_s4;
	logic signed [64:0] zp_s4;

	// Stage 1: magnitude, both unit products
	assign mag   = angle[31] ? (~angle + 32'd1) : angle;
	assign dprod = 65'(mag) * DEG_RECIP_W;
	assign rprod = 64'(mag) * e2r_pkg::RAD_TO_PHASE + 64'd134217728;

	always_ff @(posedge clk) begin
		m_s1   <= mag;
		qd_s1  <= dprod[64:38];
		pr_s1  <= rprod[61:28];
		neg_s1 <= angle[31];
		deg_s1 <= deg;
	end

	// Stage 2: remainder of the division by 45
	assign qm = 32'(qd_s1) * 32'd45;

	always_ff @(posedge clk) begin
		rem_s2 <= 6'(m_s1 - qm);
		qd_s2  <= qd_s1[25:0];
		pr_s2  <= pr_s1;
		neg_s2 <= neg_s1;
		deg_s2 <= deg_s1;
	end

	// Stage 3: fraction of the division, sign, quadrant split
	assign v2     = {rem_s2, 9'd0} + 15'd22;
	assign q2prod = 31'(v2) * e2r_pkg::FRAC_RECIP;
	assign pdeg   = {qd_s2[24:0], q2prod[29:21]};
	assign phase  = deg_s2 ? pdeg : pr_s2;
	assign sph    = neg_s2 ? (34'd0 - phase) : phase;
	assign t      = sph + 34'h080000000;

	always_ff @(posedge clk) begin
		quad_s3 <= t[33:32];
		r_s3    <= {~t[31], t[30:0]};
	end

	// Stage 4: residual to Q30 radians
	always_ff @(posedge clk) begin
		quad_s4 <= quad_s3;
		zp_s4   <= 65'(r_s3) * e2r_pkg::PI_Q30 + 65'sd4294967296;
	end

	assign quad = quad_s4;
	assign z    = {zp_s4[63], zp_s4[63:33]};

endmodule

// File: rtl/core/e2r_cordic.sv
`timescale 1ns / 1ps
// Rotation-mode CORDIC, one micro-rotation per stage, then clamp and
// quadrant fold to cosine and sine in Q2.30. Uses e2r_pkg.
module e2r_cordic (
	input  logic               clk,
	input  logic [1:0]         quad,
	input  logic signed [31:0] z,
	output e2r_pkg::ent_t      cos_val,
	output e2r_pkg::ent_t      sin_val
);

	logic signed [e2r_pkg::XW-1:0] x_s [e2r_pkg::CORDIC_STEPS+1];
	logic signed [e2r_pkg::XW-1:0] y_s [e2r_pkg::CORDIC_STEPS+1];
	logic signed [31:0]            z_s [e2r_pkg::CORDIC_STEPS+1];
	logic [1:0]                    q_s [e2r_pkg::CORDIC_STEPS+1];

	e2r_pkg::ent_t xc, yc, cos_s32, sin_s32;

	always_ff @(posedge clk) begin
		x_s[0] <= e2r_pkg::CORDIC_GAIN;
		y_s[0] <= '0;
		z_s[0] <= z;
		q_s[0] <= quad;
	end

	for (genvar i = 0; i < e2r_pkg::CORDIC_STEPS; i++) begin : g_step
		always_ff @(posedge clk) begin
			q_s[i+1] <= q_s[i];
			if (!z_s[i][31]) begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - $signed(e2r_pkg::ATAN_TABLE[i]);
			end else begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + $signed(e2r_pkg::ATAN_TABLE[i]);
			end
		end
	end

	assign xc = e2r_pkg::sat_q30(64'(x_s[e2r_pkg::CORDIC_STEPS]));
	assign yc = e2r_pkg::sat_q30(64'(y_s[e2r_pkg::CORDIC_STEPS]));

	// Fold back by whole quarter turns
	always_ff @(posedge clk) begin
		unique case (q_s[e2r_pkg::CORDIC_STEPS])
			2'd0: begin
				cos_s32 <= xc;  sin_s32 <= yc;
			end
			2'd1: begin
				cos_s32 <= -yc; sin_s32 <= xc;
			end
			2'd2: begin
				cos_s32 <= -xc; sin_s32 <= -yc;
			end
			default: begin
				cos_s32 <= yc;  sin_s32 <= -xc;
			end
		endcase
	end

	assign cos_val = cos_s32;
	assign sin_val = sin_s32;

endmodule

// File: rtl/core/e2r_matmul.sv
`timescale 1ns / 1ps
// 3x3 Q2.30 matrix product: registered partial products, then sum, round
// to nearest and clamp. Two stages. Uses e2r_pkg.
module e2r_matmul (
	input  logic          clk,
	input  e2r_pkg::mat_t a,
	input  e2r_pkg::mat_t b,
	output e2r_pkg::mat_t r
);

	logic signed [63:0] p_s1 [27];
	e2r_pkg::mat_t      r_s2;

	for (genvar i = 0; i < 3; i++) begin : g_row
		for (genvar j = 0; j < 3; j++) begin : g_col
			for (genvar l = 0; l < 3; l++) begin : g_term
				always_ff @(posedge clk) begin
					p_s1[(i*3+j)*3+l] <= 64'(a[i*3+l]) * 64'(b[l*3+j]);
				end
			end
			always_ff @(posedge clk) begin
				r_s2[i*3+j] <= e2r_pkg::sat_q30((p_s1[(i*3+j)*3] + p_s1[(i*3+j)*3+1]
					+ p_s1[(i*3+j)*3+2] + 64'sd536870912) >>> 30);
			end
		end
	end

	assign r = r_s2;

endmodule

// File: rtl/core/euler_angles_to_rotation_matrix.sv
`timescale 1ns / 1ps
// Top level: Euler angles to 3x3 rotation matrix, fully pipelined.
// Uses e2r_pkg, e2r_phase, e2r_cordic and e2r_matmul.
//
//  channel  | ports                          | handshake
//  ---------+--------------------------------+-----------------------------
//  command  | start, busy, cmd               | word taken when start & !busy
//  result   | done, result                   | word valid for one cycle
//  config   | cfg_valid, cfg_ready, cfg_data | written when valid & ready
//
// One command word may enter every clock; busy stays low. The result word
// passes through the angle conversion, the 31-stage CORDIC chain and the
// two matrix products after the command is taken.
// Reset clears the valid line and sets degree mode; payload stages carry no
// reset. The receiver cannot stall, so the pipeline never holds.
module euler_angles_to_rotation_matrix (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  e2r_pkg::e2r_in_t  cmd,
	output logic              done,
	output e2r_pkg::e2r_out_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_data
);

	logic angle_in_degrees_q;
	logic take;
	logic [e2r_pkg::TOTAL_LAT-1:0] vld_q;
	logic [e2r_pkg::TOTAL_LAT-1:0] op_q;

	logic [1:0]         quad [3];
	logic signed [31:0] zres [3];
	e2r_pkg::ent_t      cv [3];
	e2r_pkg::ent_t      sv [3];

	e2r_pkg::ent_t c3_s1, s3_s1, c3_s2, s3_s2;
	e2r_pkg::mat_t f1, f2, f3, tmp, res;
	logic op_a, op_b;

	// Never back-pressure the sender: the pipeline advances every cycle
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign take      = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_in_degrees_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			angle_in_degrees_q <= cfg_data;
		end
	end

	// Valid line and rotation order travel alongside the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[e2r_pkg::TOTAL_LAT-2:0], take};
		end
	end

	always_ff @(posedge clk) begin
		op_q <= {op_q[e2r_pkg::TOTAL_LAT-2:0], cmd.operation};
	end

	// One conversion and CORDIC chain per angle
	e2r_phase u_phase0 (.clk(clk), .angle(cmd.first_angle),  .deg(angle_in_degrees_q),
		.quad(quad[0]), .z(zres[0]));
	e2r_phase u_phase1 (.clk(clk), .angle(cmd.second_angle), .deg(angle_in_degrees_q),
		.quad(quad[1]), .z(zres[1]));
	e2r_phase u_phase2 (.clk(clk), .angle(cmd.third_angle),  .deg(angle_in_degrees_q),
		.quad(quad[2]), .z(zres[2]));

	for (genvar k = 0; k < 3; k++) begin : g_trig
		e2r_cordic u_cordic (.clk(clk), .quad(quad[k]), .z(zres[k]),
			.cos_val(cv[k]), .sin_val(sv[k]));
	end

	// Hold the third angle's cosine and sine while the first product runs
	always_ff @(posedge clk) begin
		c3_s1 <= cv[2];
		s3_s1 <= sv[2];
		c3_s2 <= c3_s1;
		s3_s2 <= s3_s1;
	end

	assign op_a = op_q[e2r_pkg::ROT_LAT-1];
	assign op_b = op_q[e2r_pkg::ROT_LAT-1+e2r_pkg::MM_LAT];

	// Outer factors swap axes with the order; the middle one is always Y
	assign f1 = e2r_pkg::make_rot((op_a == e2r_pkg::OP_ZYX) ? e2r_pkg::AXIS_Z : e2r_pkg::AXIS_X,
		cv[0], sv[0]);
	assign f2 = e2r_pkg::make_rot(e2r_pkg::AXIS_Y, cv[1], sv[1]);
	assign f3 = e2r_pkg::make_rot((op_b == e2r_pkg::OP_ZYX) ? e2r_pkg::AXIS_X : e2r_pkg::AXIS_Z,
		c3_s2, s3_s2);

	e2r_matmul u_mm_first  (.clk(clk), .a(f1),  .b(f2), .r(tmp));
	e2r_matmul u_mm_second (.clk(clk), .a(tmp), .b(f3), .r(res));

	assign done             = vld_q[e2r_pkg::TOTAL_LAT-1];
	assign result.row0_col0 = res[0];
	assign result.row0_col1 = res[1];
	assign result.row0_col2 = res[2];
	assign result.row1_col0 = res[3];
	assign result.row1_col1 = res[4];
	assign result.row1_col2 = res[5];
	assign result.row2_col0 = res[6];
	assign result.row2_col1 = res[7];
	assign result.row2_col2 = res[8];

`ifndef SYNTH
	a_latency : assert property (@(posedge clk) disable iff (!arst_n)
		take |-> ##(e2r_pkg::TOTAL_LAT) done)
		else $error("command word did not produce a result word in time");

	a_no_orphan : assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(take, e2r_pkg::TOTAL_LAT))
		else $error("result word without a matching command word");

	a_diag_range : assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.row1_col1 <= 32'sd1073741824 && result.row1_col1 >= -32'sd1073741824))
		else $error("matrix entry outside +-1.0");
`endif

endmodule

// File: tb/tb_euler_angles_to_rotation_matrix.sv
`timescale 1ns / 1ps
// Testbench for euler_angles_to_rotation_matrix: bursts of angle words in both
// unit modes, each result word checked against an in-bench bit-exact model.
// Depends on e2r_pkg and the RTL under rtl/core.
module tb_euler_angles_to_rotation_matrix;

	localparam int LIMIT = 400000;

	// CORDIC arctangents, Q30 radians
	localparam longint ARCTAN [31] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
		64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
		64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
		64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
		64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
		64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
		64'h00000001
	};
	localparam longint UNITY = 64'sd1073741824;

	logic clk, arst_n, start, busy, done, cfg_valid, cfg_ready, cfg_data;
	e2r_pkg::e2r_in_t cmd;
	e2r_pkg::e2r_out_t result;

	euler_angles_to_rotation_matrix u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .result(result), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	e2r_pkg::e2r_in_t  pending_cmds [$];
	e2r_pkg::e2r_out_t expected_mats [$];
	bit  degree_mode;
	int  mismatches, cycles;
	bit  feed_paused;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Floor shift of a signed value
	function automatic longint floor_shift(longint v, int n);
		return v >>> n;
	endfunction

	function automatic longint clamp_unit(longint v);
		if (v > UNITY) return UNITY;
		if (v < -UNITY) return -UNITY;
		return v;
	endfunction

	// Angle word to phase in 2^-34 turns
	function automatic longint unsigned angle_phase(logic signed [31:0] a, bit deg);
		longint unsigned mag, ph;
		longint sa;
		logic [127:0] wide;
		sa = a;
		mag = (sa < 0) ? longint'(-sa) : longint'(sa);
		if (deg) begin
			ph = (mag * 512 + 22) / 45;
		end else begin
			wide = 128'(mag) * 128'd2734261102 + 128'(64'd1 << 27);
			ph = wide[91:28];
		end
		if (sa < 0) ph = 64'd0 - ph;
		return ph & 64'h3FFFFFFFF;
	endfunction

	// Cosine and sine of one angle in Q30
	task automatic cos_sin(input logic signed [31:0] a, input bit deg,
			output longint c, output longint s);
		longint unsigned t;
		longint r, z, x, y, nx;
		int quad;
		t = (angle_phase(a, deg) + (64'd1 << 31)) & 64'h3FFFFFFFF;
		quad = int'(t >> 32);
		r = longint'(t & 64'hFFFFFFFF) - 64'sd2147483648;
		z = floor_shift(r * 64'sd3373259426 + (64'sd1 <<< 32), 33);
		x = 64'sd652032874;
		y = 0;
		for (int i = 0; i < 31; i++) begin
			if (z >= 0) begin
				nx = x - floor_shift(y, i); y = y + floor_shift(x, i); z -= ARCTAN[i];
			end else begin
				nx = x + floor_shift(y, i); y = y - floor_shift(x, i); z += ARCTAN[i];
			end
			x = nx;
		end
		x = clamp_unit(x);
		y = clamp_unit(y);
		case (quad)
			0: begin c = x; s = y; end
			1: begin c = -y; s = x; end
			2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
	endtask

	// axis 0 = X, 1 = Y, 2 = Z
	task automatic axis_rotation(input int axis, input logic signed [31:0] a,
			input bit deg, output longint m [9]);
		longint c, s;
		cos_sin(a, deg, c, s);
		foreach (m[k]) m[k] = 0;
		if (axis == 0) begin
			m[0] = UNITY; m[4] = c; m[5] = -s; m[7] = s; m[8] = c;
		end else if (axis == 1) begin
			m[0] = c; m[2] = s; m[4] = UNITY; m[6] = -s; m[8] = c;
		end else begin
			m[0] = c; m[1] = -s; m[3] = s; m[4] = c; m[8] = UNITY;
		end
	endtask

	task automatic product_q30(input longint a [9], input longint b [9], output longint r [9]);
		longint acc;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				acc = 0;
				for (int l = 0; l < 3; l++) acc += a[i*3+l] * b[l*3+j];
				r[i*3+j] = clamp_unit(floor_shift(acc + (64'sd1 <<< 29), 30));
			end
	endtask

	task automatic predict_matrix(input e2r_pkg::e2r_in_t w, input bit deg,
			output e2r_pkg::e2r_out_t o);
		longint f1 [9], f2 [9], f3 [9], t [9], m [9];
		int outer;
		outer = (w.operation == e2r_pkg::OP_ZYX) ? 2 : 0;
		axis_rotation(outer, w.first_angle, deg, f1);
		axis_rotation(1, w.second_angle, deg, f2);
		axis_rotation(2 - outer, w.third_angle, deg, f3);
		product_q30(f1, f2, t);
		product_q30(t, f3, m);
		o.row0_col0 = m[0][31:0]; o.row0_col1 = m[1][31:0]; o.row0_col2 = m[2][31:0];
		o.row1_col0 = m[3][31:0]; o.row1_col1 = m[4][31:0]; o.row1_col2 = m[5][31:0];
		o.row2_col0 = m[6][31:0]; o.row2_col1 = m[7][31:0]; o.row2_col2 = m[8][31:0];
	endtask

	// Sample busy at the rising edge so the driver knows whether its word went in
	logic busy_at_edge;
	always @(posedge clk) busy_at_edge <= busy;

	// Driver: take words from the pending queue in bursts, with gaps between
	int burst_left, gap_left;
	always @(negedge clk) begin
		if (arst_n) begin
			// drop the word taken at the last rising edge
			if (start && !busy_at_edge) void'(pending_cmds.pop_front());
			if (gap_left > 0 || feed_paused || pending_cmds.size() == 0) begin
				if (gap_left > 0) gap_left--;
				start <= 1'b0;
			end else begin
				start <= 1'b1;
				cmd <= pending_cmds[0];
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 30);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end
		end
	end

	// Expectations are queued at the edge that takes the word
	always @(posedge clk) begin
		e2r_pkg::e2r_out_t exp_w;
		if (arst_n && start && !busy) begin
			predict_matrix(cmd, degree_mode, exp_w);
			expected_mats.push_back(exp_w);
		end
	end

	// Monitor: compare each result word with the oldest expectation
	always @(posedge clk) begin
		e2r_pkg::e2r_out_t exp_w;
		if (arst_n && done) begin
			if (expected_mats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result word %h", result);
			end else begin
				exp_w = expected_mats.pop_front();
				if (exp_w !== result) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h got %h", exp_w, result);
				end
			end
		end
	end

	// Run watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic logic [31:0] pick_angle();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return $urandom_range(0, 1) ? 32'h05A0_0000 * $urandom_range(0, 3)
				: -(32'h05A0_0000 * $urandom_range(0, 3));
			default: return $urandom;
		endcase
	endfunction

	task automatic queue_word(bit op, logic [31:0] a, logic [31:0] b, logic [31:0] c);
		e2r_pkg::e2r_in_t w;
		w.operation = op; w.first_angle = a; w.second_angle = b; w.third_angle = c;
		pending_cmds.push_back(w);
	endtask

	// Wait until everything queued has gone in and come out, then flush
	task automatic drain();
		while (pending_cmds.size() != 0 || start || expected_mats.size() != 0)
			@(posedge clk);
		repeat (e2r_pkg::TOTAL_LAT + 5) @(posedge clk);
	endtask

	task automatic write_units(bit deg);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= deg;
		do @(posedge clk); while (!cfg_ready);
		degree_mode = deg;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		bit modes [4];
		modes = '{1'b0, 1'b1, 1'b0, 1'b1};
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		cfg_valid = 1'b0;
		cfg_data = 1'b1;
		degree_mode = 1'b1;
		burst_left = 0;
		gap_left = 0;
		feed_paused = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: zeros, extremes, right angles and both orders in degree mode
		for (int op = 0; op < 2; op++) begin
			queue_word(op, 0, 0, 0);
			queue_word(op, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
			queue_word(op, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
			queue_word(op, 32'h1680_0000, 32'h1680_0000, 32'h1680_0000);
			queue_word(op, 32'h0B40_0000, -32'sh0B40_0000, 32'h2D00_0000);
			queue_word(op, 32'hFFFF_FFFF, 32'h0000_0001, 32'h5555_5555);
		end
		drain();
		write_units(1'b0);
		for (int op = 0; op < 2; op++) begin
			queue_word(op, 32'h1921_FB54, 32'h3243_F6A8, 32'hE6DE_04AC);
			queue_word(op, 32'h7FFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA);
		end
		drain();

		// Random phases in alternating unit modes
		foreach (modes[p]) begin
			write_units(modes[p]);
			for (int n = 0; n < 125; n++)
				queue_word($urandom_range(0, 1), pick_angle(), pick_angle(), pick_angle());
			if (p == 1) begin
				// hold the feed until the pipeline is empty once mid-phase
				while (pending_cmds.size() > 60) @(posedge clk);
				feed_paused = 1'b1;
				while (expected_mats.size() != 0 || start) @(posedge clk);
				feed_paused = 1'b0;
			end
			drain();
		end

		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
